// ===== hw/rtl/lpfw_pkg.sv =====
// types and constants shared by the lcd page mode frame writer
package lpfw_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int PAGE_W  = 4;
  localparam int STORE_W = 7;

  localparam logic [7:0] OFFSET_RESET = 8'd4;
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HI   = 8'h10;
  localparam logic [7:0] COL_LO_MASK  = 8'h0F;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // phases of a page-start burst
  localparam logic [1:0] PH_PAGE   = 2'd0;
  localparam logic [1:0] PH_COL_HI = 2'd1;
  localparam logic [1:0] PH_COL_LO = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic       frame_end;
  } out_t;

  // one queued column byte, with the page commands in front of it when needed
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              with_cmds;
    logic [PAGE_W-1:0] page;
    logic              frame_end;
  } lpfw_rec_t;

endpackage

// ===== hw/rtl/lpfw_ram.sv =====
// generic single write, single read ram with registered read data
module lpfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lpfw_out_queue.sv =====
// result queue that expands each column record into commands and data bytes
module lpfw_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lpfw_pkg::lpfw_rec_t         push_rec,
  input  logic [7:0]                  column_offset,
  output logic [lpfw_pkg::QCNT_W-1:0] level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lpfw_pkg::out_t              out_data
);
  import lpfw_pkg::*;

  lpfw_rec_t         rec_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        ph_r, ph_nxt;
  lpfw_rec_t         head;
  logic              in_data_ph;
  logic              take;
  logic              pop;

  assign head       = rec_r[rd_ptr_r];
  assign out_valid  = (cnt_r != '0);
  assign in_data_ph = !head.with_cmds || (ph_r == PH_DATA);
  assign take       = out_valid && !out_stall;
  assign pop        = take && in_data_ph;
  assign level      = cnt_r;

  always_comb begin
    out_data.is_data   = in_data_ph;
    out_data.last      = in_data_ph;
    out_data.frame_end = in_data_ph && head.frame_end;
    out_data.out_byte  = head.data_byte;
    if (!in_data_ph) begin
      case (ph_r)
        PH_PAGE:   out_data.out_byte = CMD_PAGE | {{(8 - PAGE_W){1'b0}}, head.page};
        PH_COL_HI: out_data.out_byte = CMD_COL_HI | {4'd0, column_offset[7:4]};
        PH_COL_LO: out_data.out_byte = column_offset & COL_LO_MASK;
        default:   out_data.out_byte = head.data_byte;
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    ph_nxt     = ph_r;
    if (pop) begin
      ph_nxt = PH_PAGE;
    end else if (take) begin
      ph_nxt = ph_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      ph_r     <= PH_PAGE;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      ph_r     <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rec_r[wr_ptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_cmd_phase_has_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != PH_PAGE |-> out_valid && head.with_cmds)
    else $error("command phase without a page-start record");

  a_stalled_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(ph_r) && $stable(rd_ptr_r))
    else $error("burst advanced while stalled");

  a_ptr_level_agree: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== hw/rtl/lcd_page_mode_frame_writer.sv =====
// top level of the lcd page mode frame writer
//
// Pixels arrive on in_valid/in_data/in_stall in row-major order, one request
// per pixel; only bit 7 of pixel counts. frame_start puts a pixel at row 0,
// column 0. Rows 0..6 of each 8-row page go into a per-column ram; the pixel
// in the page's eighth row reads the column back and produces one data byte
// (top row in bit 0). At column 0 of a page three command bytes come first:
// page address, column high, column low from cfg_wdata (written by cfg_we,
// reset value 4; write it only while idle, the block does not enforce this).
// Results leave on out_valid/out_data/out_stall from a four-entry queue.
// An item can be taken every cycle while in_stall is low; its data byte
// passes through the stage-1 register into the queue before it is offered.
// The page-start burst adds three command bytes of output, so with a free
// receiver the pixel side still stalls during the burst at column 0 of each
// page's eighth row. The ram read is registered and stage 1 writes back,
// forwarding the previous pixel's write when the same column is read again.
// in_stall rises only when the result queue could not absorb the items in
// flight, so a stalled receiver backs up into the pixel channel after a few
// results. Reset clears position, queue and pipeline; the column ram is not
// cleared since each page writes an entry before it reads it.
module lcd_page_mode_frame_writer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  lpfw_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lpfw_pkg::out_t out_data
);
  import lpfw_pkg::*;

  logic [7:0]         col_off_r;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_sel;
  logic [COL_W-1:0]   col_sel;
  logic               accept;

  // stage 1: ram data is back, modify and write
  logic               s1_valid_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_bit_r;
  logic               s1_fwd_r;
  logic [STORE_W-1:0] s1_fwd_data_r;

  logic [STORE_W-1:0] ram_rdata;
  logic [STORE_W-1:0] entry;
  logic [2:0]         rip;
  logic               s1_we;
  logic [STORE_W-1:0] s1_wdata;
  logic               s1_push;
  lpfw_rec_t          s1_rec;
  logic [QCNT_W-1:0]  q_level;

  assign accept  = in_valid && !in_stall;
  assign row_sel = in_data.frame_start ? '0 : row_r;
  assign col_sel = in_data.frame_start ? '0 : col_r;

  always_comb begin
    col_nxt = col_sel + 1'b1;
    row_nxt = row_sel;
    if (col_sel == COL_W'(COLUMNS - 1)) begin
      col_nxt = '0;
      row_nxt = (row_sel == ROW_W'(ROWS - 1)) ? '0 : row_sel + 1'b1;
    end
  end

  assign rip   = s1_row_r[2:0];
  assign entry = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign s1_we = s1_valid_r && (rip != 3'd7);

  always_comb begin
    if (rip == 3'd0) begin
      s1_wdata = {{(STORE_W - 1){1'b0}}, s1_bit_r};
    end else begin
      s1_wdata = entry | (STORE_W'(s1_bit_r) << rip);
    end
  end

  assign s1_push          = s1_valid_r && (rip == 3'd7);
  assign s1_rec.data_byte = {s1_bit_r, entry};
  assign s1_rec.with_cmds = (s1_col_r == '0);
  assign s1_rec.page      = PAGE_W'(s1_row_r >> 3);
  assign s1_rec.frame_end = (s1_row_r == ROW_W'(ROWS - 1)) &&
                            (s1_col_r == COL_W'(COLUMNS - 1));

  // room for the record now in stage 1 plus one more
  assign in_stall = (q_level + QCNT_W'(s1_push)) >= QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r  <= OFFSET_RESET;
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        col_off_r <= cfg_wdata;
      end
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r      <= row_sel;
      s1_col_r      <= col_sel;
      s1_bit_r      <= in_data.pixel[7];
      s1_fwd_r      <= s1_we && (s1_col_r == col_sel);
      s1_fwd_data_r <= s1_wdata;
    end
  end

  lpfw_ram #(
    .WIDTH (STORE_W),
    .DEPTH (COLUMNS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (s1_we),
    .wr_addr (s1_col_r),
    .wr_data (s1_wdata),
    .rd_en   (accept),
    .rd_addr (col_sel),
    .rd_data (ram_rdata)
  );

  lpfw_out_queue u_out_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (s1_push),
    .push_rec      (s1_rec),
    .column_offset (col_off_r),
    .level         (q_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
